FILE: src/ptd_pkg.sv
`timescale 1ns / 1ps

package ptd_pkg;

	// Table size and derived widths.
	localparam int NUM_TASKS   = 8;
	localparam int MAX_RESULTS = 8;
	localparam int SLOT_W      = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int CNT_W       = $clog2(NUM_TASKS + 1);
	localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

	// Field widths of the request and result channels, the tick counter and its step count.
	localparam int OP_W     = 3;
	localparam int IDX_W    = 3;
	localparam int PERIOD_W = 16;
	localparam int TICK_W   = 32;
	localparam int STEP_W   = $clog2(TICK_W);

	// Operation codes.
	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_CREATE  = 3'd1;
	localparam logic [OP_W-1:0] OP_SUSPEND = 3'd2;
	localparam logic [OP_W-1:0] OP_RESUME  = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE  = 3'd4;

	// What the output register is loaded with.
	typedef enum logic [1:0] {
		PUSH_ACK,
		PUSH_PEND,
		PUSH_PEND_LAST
	} push_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       in_ready;
		logic       mod_start;
		logic       slot_next;
		logic       pend_set;
		logic       push;
		push_kind_t push_kind;
	} ptd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_valid;
		logic in_tick;
		logic scan_end;
		logic eligible;
		logic mod_busy;
		logic rem_zero;
		logic pend_valid;
		logic out_free;
	} ptd_stat_t;

endpackage

FILE: src/ptd_req_if.sv
`timescale 1ns / 1ps

interface ptd_req_if import ptd_pkg::*;;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [IDX_W-1:0]    task_index;
	logic [PERIOD_W-1:0] period;

	modport source (output valid, output opcode, output task_index, output period,
		input ready);
	modport sink (input valid, input opcode, input task_index, input period,
		output ready);
endinterface

FILE: src/ptd_res_if.sv
`timescale 1ns / 1ps

interface ptd_res_if import ptd_pkg::*;;
	logic             valid;
	logic             ready;
	logic             fired;
	logic [IDX_W-1:0] fired_index;
	logic             last;

	modport source (output valid, output fired, output fired_index, output last,
		input ready);
	modport sink (input valid, input fired, input fired_index, input last,
		output ready);
endinterface

FILE: src/ptd_datapath.sv
`timescale 1ns / 1ps

module ptd_datapath import ptd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ptd_req_if.sink   req,
	ptd_res_if.source res,
	input  ptd_cmd_t  cmd,
	output ptd_stat_t st
);

	logic                slot_valid_q  [NUM_TASKS];
	logic                slot_ready_q  [NUM_TASKS];
	logic [PERIOD_W-1:0] slot_period_q [NUM_TASKS];
	logic [TICK_W-1:0]   tick_count_q;
	logic [TICK_W-1:0]   tick_snap_q;

	logic [CNT_W-1:0]    slot_q;
	logic [FOUND_W-1:0]  found_q;
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_idx_q;

	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] div_q;
	logic [TICK_W-1:0]   dvd_q;
	logic [STEP_W-1:0]   step_q;
	logic                mod_busy_q;

	logic                out_valid_q;
	logic                out_fired_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic                out_last_q;

	logic                accept;
	logic                in_range;
	logic [SLOT_W-1:0]   wr_idx;
	logic [SLOT_W-1:0]   slot_sel;
	logic                out_free;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W:0]   diff;

	// Request handshake and decoding.
	assign req.ready = cmd.in_ready;
	assign accept    = req.valid & req.ready;
	assign in_range  = (32'(req.task_index) < NUM_TASKS);
	assign wr_idx    = SLOT_W'(req.task_index);
	assign slot_sel  = slot_q[SLOT_W-1:0];

	// Task table updates, applied when the request is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TASKS; i++) begin
				slot_valid_q[i]  <= 1'b0;
				slot_ready_q[i]  <= 1'b0;
				slot_period_q[i] <= '0;
			end
		end else if (accept && in_range) begin
			unique case (req.opcode)
				OP_CREATE: begin
					slot_period_q[wr_idx] <= req.period;
					slot_valid_q[wr_idx]  <= 1'b1;
					slot_ready_q[wr_idx]  <= 1'b1;
				end
				OP_SUSPEND: slot_ready_q[wr_idx] <= 1'b0;
				OP_RESUME:  slot_ready_q[wr_idx] <= 1'b1;
				OP_DELETE: begin
					slot_period_q[wr_idx] <= '0;
					slot_valid_q[wr_idx]  <= 1'b0;
					slot_ready_q[wr_idx]  <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Tick counter; the scan works on a copy taken before the increment.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (accept && req.opcode == OP_TICK) begin
			tick_count_q <= tick_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.opcode == OP_TICK) begin
			tick_snap_q <= tick_count_q;
		end
	end

	// Scan position, due-task count and the one held-back result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			found_q      <= '0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			slot_q       <= '0;
			found_q      <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.slot_next) begin
				slot_q <= slot_q + 1'b1;
			end
			if (cmd.pend_set) begin
				found_q      <= found_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pend_set) begin
			pend_idx_q <= IDX_W'(slot_sel);
		end
	end

	// Restoring remainder unit, one dividend bit per cycle.
	assign trial = {rem_q, dvd_q[TICK_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			step_q     <= '0;
		end else if (cmd.mod_start) begin
			mod_busy_q <= 1'b1;
			step_q     <= '0;
		end else if (mod_busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(TICK_W - 1)) begin
				mod_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			div_q <= slot_period_q[slot_sel];
			dvd_q <= tick_snap_q;
			rem_q <= '0;
		end else if (mod_busy_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			rem_q <= diff[PERIOD_W] ? trial[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
		end
	end

	// Output register.
	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			case (cmd.push_kind)
				PUSH_PEND: begin
					out_fired_q <= 1'b1;
					out_idx_q   <= pend_idx_q;
					out_last_q  <= 1'b0;
				end
				PUSH_PEND_LAST: begin
					out_fired_q <= 1'b1;
					out_idx_q   <= pend_idx_q;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_fired_q <= 1'b0;
					out_idx_q   <= '0;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign res.valid       = out_valid_q;
	assign res.fired       = out_fired_q;
	assign res.fired_index = out_idx_q;
	assign res.last        = out_last_q;

	// Status toward the controller.
	always_comb begin
		st.in_valid   = req.valid;
		st.in_tick    = (req.opcode == OP_TICK);
		st.scan_end   = (slot_q == CNT_W'(NUM_TASKS)) ||
			(found_q == FOUND_W'(MAX_RESULTS));
		st.eligible   = slot_valid_q[slot_sel] && slot_ready_q[slot_sel] &&
			(slot_period_q[slot_sel] != '0);
		st.mod_busy   = mod_busy_q;
		st.rem_zero   = (rem_q == '0);
		st.pend_valid = pend_valid_q;
		st.out_free   = out_free;
	end

endmodule

FILE: src/ptd_ctrl.sv
`timescale 1ns / 1ps

module ptd_ctrl import ptd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ptd_stat_t st,
	output ptd_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ACK   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_HIT   = 3'd4;
	localparam logic [2:0] S_FLUSH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		cmd.in_ready  = 1'b0;
		cmd.mod_start = 1'b0;
		cmd.slot_next = 1'b0;
		cmd.pend_set  = 1'b0;
		cmd.push      = 1'b0;
		cmd.push_kind = PUSH_ACK;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (st.in_valid) begin
					state_d = st.in_tick ? S_SCAN : S_ACK;
				end
			end
			S_ACK: begin
				if (st.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_SCAN: begin
				if (st.scan_end) begin
					state_d = S_FLUSH;
				end else if (st.eligible) begin
					cmd.mod_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.slot_next = 1'b1;
				end
			end
			S_DIV: begin
				if (!st.mod_busy) begin
					if (st.rem_zero) begin
						state_d = S_HIT;
					end else begin
						cmd.slot_next = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_HIT: begin
				// A due task is held back until the next one shows whether it is the last.
				if (!st.pend_valid) begin
					cmd.pend_set  = 1'b1;
					cmd.slot_next = 1'b1;
					state_d       = S_SCAN;
				end else if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = PUSH_PEND;
					cmd.pend_set  = 1'b1;
					cmd.slot_next = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_kind = st.pend_valid ? PUSH_PEND_LAST : PUSH_ACK;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/periodic_task_dispatcher_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Fields                          Meaning
// req      in         opcode, task_index, period      one operation on the task table
// res      out        fired, fired_index, last        acknowledgment or one due task
//
// Create, suspend, resume, delete and unknown opcodes are acknowledged: the
// acknowledgment is loaded once the output register is free after the request
// is taken, and the block is ready again in the cycle where it appears.
// A tick walks the slots one per cycle while it skips them. Each valid, ready
// slot with a nonzero period goes through the serial remainder unit (32 steps,
// one bit per cycle of the 32-bit tick count, and a check), and a due slot
// also passes through S_HIT, where a stalled result channel can hold it.
// Reset clears the table, the tick counter and all control state at once.
// A stalled result channel holds the scan at its next result; requests are
// taken whenever the controller is idle, even while a result still waits.

module periodic_task_dispatcher_top import ptd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ptd_req_if.sink   req,
	ptd_res_if.source res
);

	ptd_cmd_t  cmd;
	ptd_stat_t st;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	ptd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.st     (st)
	);

	// A result is never loaded over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> st.out_free)
		else $error("result register overwritten");

	// Only one request is in flight: the block is busy right after taking one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken while busy");

	// The remainder unit runs once it is started.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.mod_start |=> st.mod_busy)
		else $error("remainder unit did not start");

	// A result that reports no due task is always the final one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.fired) |-> res.last)
		else $error("non-fired result not marked last");

endmodule
